[rtl/core/sefm_pkg.sv]
// shared types and constants of the signal event flag multiplexer
package sefm_pkg;

  localparam int unsigned NumClientsDef = 16;

  localparam logic [7:0] MasterId = 8'd128;

  localparam logic OpPost = 1'b0;
  localparam logic OpWait = 1'b1;

  localparam logic KindReply = 1'b0;
  localparam logic KindWake  = 1'b1;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusDenied = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic rd_en;     // read client state at the current index
    logic ev_en;     // update client state and emit a result if any
    logic idx_inc;   // step to the next client
    logic reply_en;  // emit the final reply
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;        // latched operation
    logic err;       // latched request is not permitted
    logic out_free;  // result register can take a result this cycle
    logic idx_last;  // index is at the last client
  } sts_t;

endpackage

[rtl/core/sefm_ctrl.sv]
// controller state machine of the signal event flag multiplexer
module sefm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sefm_pkg::sts_t  sts_i,
  output sefm_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StEval  = 2'd2;
  localparam logic [1:0] StReply = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = sts_i.err ? StReply : StEval;
      end
      StEval: begin
        // hold here until the result register has room
        if (sts_i.out_free) begin
          cmd_o.ev_en = 1'b1;
          if (sts_i.op == sefm_pkg::OpWait) begin
            state_d = StIdle;
          end else if (sts_i.idx_last) begin
            state_d = StReply;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = StRead;
          end
        end
      end
      StReply: begin
        if (sts_i.out_free) begin
          cmd_o.reply_en = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/sefm_dp.sv]
// datapath of the signal event flag multiplexer: client state and result register
module sefm_dp #(
  parameter int unsigned NumClients = sefm_pkg::NumClientsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_i,
  input  logic [7:0]      caller_i,
  input  logic [31:0]     signal_mask_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output logic [3:0]      target_client_o,
  output logic [31:0]     signals_o,
  output logic            status_o,
  output logic            last_o,
  input  sefm_pkg::cmd_t  cmd_i,
  output sefm_pkg::sts_t  sts_o
);

  localparam int unsigned IdxW = (NumClients > 1) ? $clog2(NumClients) : 1;

  // request registers
  logic            op_q;
  logic [7:0]      caller_q;
  logic [31:0]     mask_q;
  logic [IdxW-1:0] idx_q;

  // client state: masks in memory, valid and sleeping bits in flops
  logic [31:0]           pend_mem [NumClients];
  logic [31:0]           wait_mem [NumClients];
  logic [NumClients-1:0] valid_q;
  logic [NumClients-1:0] sleep_q;

  logic [31:0] pend_rd_q, wait_rd_q;
  logic        valid_rd_q;

  // result register
  logic        out_valid_q;
  logic        kind_q;
  logic [3:0]  target_q;
  logic [31:0] signals_q;
  logic        status_q;
  logic        last_q;

  logic        out_free;
  logic [31:0] pend_eff, wait_eff, pend_new, hit;
  logic        emit;
  logic [31:0] pend_wr, wait_wr;
  logic [7:0]  idx_ext;

  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_ext  = 8'(idx_q);

  assign sts_o.op       = op_q;
  assign sts_o.err      = (op_q == sefm_pkg::OpPost) ? (caller_q != sefm_pkg::MasterId)
                                                     : (caller_q >= 8'(NumClients));
  assign sts_o.out_free = out_free;
  assign sts_o.idx_last = (idx_q == IdxW'(NumClients - 1));

  // an entry never written reads as zero
  assign pend_eff = valid_rd_q ? pend_rd_q : '0;
  assign wait_eff = valid_rd_q ? wait_rd_q : '0;

  always_comb begin
    if (op_q == sefm_pkg::OpPost) begin
      pend_new = pend_eff | mask_q;
      hit      = sleep_q[idx_q] ? (wait_eff & pend_new) : '0;
      wait_wr  = wait_eff;
    end else begin
      pend_new = pend_eff;
      hit      = mask_q & pend_eff;
      wait_wr  = mask_q;
    end
    pend_wr = pend_new & ~hit;
    emit    = (hit != '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      caller_q <= caller_i;
      mask_q   <= signal_mask_i;
    end
    if (cmd_i.rd_en) begin
      pend_rd_q <= pend_mem[idx_q];
      wait_rd_q <= wait_mem[idx_q];
    end
    if (cmd_i.ev_en) begin
      pend_mem[idx_q] <= pend_wr;
      wait_mem[idx_q] <= wait_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= sefm_pkg::OpPost;
      idx_q      <= '0;
      valid_q    <= '0;
      sleep_q    <= '0;
      valid_rd_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        op_q  <= op_i;
        idx_q <= (op_i == sefm_pkg::OpWait) ? caller_i[IdxW-1:0] : '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.rd_en) begin
        valid_rd_q <= valid_q[idx_q];
      end
      if (cmd_i.ev_en) begin
        valid_q[idx_q] <= 1'b1;
        if (op_q == sefm_pkg::OpWait) begin
          sleep_q[idx_q] <= !emit;
        end else if (emit) begin
          sleep_q[idx_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.ev_en && emit) || cmd_i.reply_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_en && emit) begin
      kind_q    <= (op_q == sefm_pkg::OpPost) ? sefm_pkg::KindWake : sefm_pkg::KindReply;
      target_q  <= idx_ext[3:0];
      signals_q <= hit;
      status_q  <= sefm_pkg::StatusOk;
      last_q    <= (op_q == sefm_pkg::OpWait);
    end else if (cmd_i.reply_en) begin
      kind_q    <= sefm_pkg::KindReply;
      target_q  <= '0;
      signals_q <= '0;
      status_q  <= sts_o.err ? sefm_pkg::StatusDenied : sefm_pkg::StatusOk;
      last_q    <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign target_client_o = target_q;
  assign signals_o       = signals_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

  a_ev_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ev_en || cmd_i.reply_en) |-> out_free)
    else $error("result loaded while the result register is full");

  a_reply_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reply_en |=> (out_valid_q && last_q && (kind_q == sefm_pkg::KindReply)))
    else $error("final reply not marked last");

  a_wake_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == sefm_pkg::KindWake)) |->
      (!last_q && (signals_q != '0) && (status_q == sefm_pkg::StatusOk)))
    else $error("malformed wake notice");

  a_denied_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == sefm_pkg::StatusDenied)) |->
      ((signals_q == '0) && (target_q == '0) && last_q))
    else $error("error reply carries data");

endmodule

[rtl/core/signal_event_flag_multiplexer_unit.sv]
// top level of the signal event flag multiplexer
// Event flag group with wait-any semantics over NumClients clients. A post
// (caller 128) ORs its mask into every client's pending signals, sends a wake
// notice to each sleeping client whose wait mask now overlaps them (in
// increasing client order) and then a final reply marked last. A wait from a
// client either replies at once with the matched pending signals or puts the
// client to sleep with no result. Requests not permitted for the caller get
// a single error reply. Client masks sit in one-port memories that are read
// and then updated, in separate states, for each client visited; a stall on
// the result side holds the work. One request is worked on at a time, and a
// finished result waits in the output register while the next request is
// taken.
module signal_event_flag_multiplexer_unit #(
  parameter int unsigned NumClients = sefm_pkg::NumClientsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  caller_i,
  input  logic [31:0] signal_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [3:0]  target_client_o,
  output logic [31:0] signals_o,
  output logic        status_o,
  output logic        last_o
);

  sefm_pkg::cmd_t cmd;
  sefm_pkg::sts_t sts;

  sefm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sefm_dp #(
    .NumClients (NumClients)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op_i),
    .caller_i        (caller_i),
    .signal_mask_i   (signal_mask_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .target_client_o (target_client_o),
    .signals_o       (signals_o),
    .status_o        (status_o),
    .last_o          (last_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
